// ===== hw/rtl/sfls_pkg.sv =====
package sfls_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAT_SLOTS  = 16;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 56;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PAT_LOW  = 2'd0;
  localparam cfg_idx_t CFG_PAT_HIGH = 2'd1;
  localparam cfg_idx_t CFG_PAT_LEN  = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  // control for the window cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // result beat, lowest field in the lowest bits
  typedef struct packed {
    logic [OUT_DATA_W-51:0] pad;
    logic                   overflow;
    logic [IDX_W-1:0]       text_length;
    logic [IDX_W-1:0]       last_index;
    logic [IDX_W-1:0]       first_index;
    logic                   found;
  } result_t;

endpackage

// ===== hw/rtl/sfls_cell.sv =====
module sfls_cell
  import sfls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  byte_t     byte_in,
  input  byte_t     pat_byte,
  input  logic      in_use,
  output byte_t     byte_out,
  output logic      hit
);

  byte_t byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctl.clear) begin
      byte_r <= '0;
    end else if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  // compare against the byte this cell takes on the current shift
  assign hit      = !in_use || (byte_in == pat_byte);
  assign byte_out = byte_r;

endmodule

// ===== hw/rtl/substring_first_last_search.sv =====
// The beat that closes the text registers its result beat in the output register, or in
// the one-deep skid stage behind it while the output register is held. Throughput: one
// text beat per cycle while the skid stage is empty; the alignment ending at each byte
// is checked in the same cycle across the row of window cells. in_tready drops only
// while the skid stage holds a result. Reset (rst_n low, synchronous) clears the pattern
// registers, the window, the counters and both output stages.
module substring_first_last_search
  import sfls_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] text_byte
  input  logic                  in_tuser,   // [0] has_byte
  input  logic                  in_tlast,   // end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] found, [16:1] first_index,
                                            // [32:17] last_index, [48:33] text_length,
                                            // [49] overflow, [55:50] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SW = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // configuration
  logic [CFG_DATA_W-1:0] pat_low_r, pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  byte_t pat_bytes [PAT_SLOTS];
  always_comb begin
    for (int k = 0; k < PAT_SLOTS / 2; k++) begin
      pat_bytes[k]               = pat_low_r[k*BYTE_W +: BYTE_W];
      pat_bytes[k + PAT_SLOTS/2] = pat_high_r[k*BYTE_W +: BYTE_W];
    end
  end

  logic [LEN_W-1:0] len_used;
  assign len_used = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;

  // handshake
  logic acc, take, eot;
  logic out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  assign in_tready = !skid_valid_r;
  assign acc       = in_tvalid && in_tready;
  assign take      = acc && in_tuser;
  assign eot       = acc && in_tlast;

  // window cells: cell j compares the byte j beats back with pattern byte len-1-j
  cell_ctl_t              ctl;
  byte_t                  win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit_vec;

  assign ctl.shift = take;
  assign ctl.clear = eot;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [LEN_W-1:0] pidx;
    logic             used;
    assign used = LEN_W'(j) < len_used;
    assign pidx = len_used - LEN_W'(j + 1);

    sfls_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  ((j == 0) ? in_tdata : win[(j == 0) ? 0 : j - 1]),
      .pat_byte (pat_bytes[pidx[LEN_W-2:0]]),
      .in_use   (used),
      .byte_out (win[j]),
      .hit      (hit_vec[j])
    );
  end

  // text state
  logic [COUNT_BITS-1:0] count_r, earliest_r, latest_r;
  logic                  any_r, ovf_r;

  logic                  at_max, long_enough, rec;
  logic [COUNT_BITS-1:0] cnt_inc, start, count_upd, earliest_upd, latest_upd;
  logic [SW-1:0]         cnt_ext, len_ext, start_ext;
  logic                  any_upd, ovf_upd;
  result_t               res;

  always_comb begin
    at_max       = (count_r == CNT_MAX);
    cnt_inc      = count_r + 1'b1;
    cnt_ext      = SW'(cnt_inc);
    len_ext      = SW'(len_used);
    long_enough  = cnt_ext >= len_ext;
    start_ext    = cnt_ext - len_ext;
    start        = start_ext[COUNT_BITS-1:0];
    rec          = take && !at_max && (len_used != '0) && long_enough && (&hit_vec);
    count_upd    = (take && !at_max) ? cnt_inc : count_r;
    ovf_upd      = ovf_r || (take && at_max);
    any_upd      = any_r || rec;
    earliest_upd = (rec && !any_r) ? start : earliest_r;
    latest_upd   = rec ? start : latest_r;

    res             = '0;
    res.text_length = IDX_W'(count_upd);
    res.overflow    = ovf_upd;
    if (len_used == '0) begin
      res.found      = 1'b1;
      res.last_index = IDX_W'(count_upd);
    end else if (any_upd) begin
      res.found       = 1'b1;
      res.first_index = IDX_W'(earliest_upd);
      res.last_index  = IDX_W'(latest_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || eot) begin
      count_r    <= '0;
      earliest_r <= '0;
      latest_r   <= '0;
      any_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      count_r    <= count_upd;
      earliest_r <= earliest_upd;
      latest_r   <= latest_upd;
      any_r      <= any_upd;
      ovf_r      <= ovf_upd;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= eot;
      end
    end else if (eot) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (eot) begin
        out_r <= res;
      end
    end else if (eot) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CNT_MAX))
    else $error("overflow flagged below the counter maximum");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> (earliest_r <= latest_r))
    else $error("earliest match lies after latest match");

  a_clear_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    eot |=> (count_r == '0) && !any_r && !ovf_r)
    else $error("text state not cleared after the closing beat");

endmodule

// ===== verif/testbench.sv =====
module testbench
  import sfls_pkg::*;
();

  localparam int unsigned WINDOW_DEPTH = 16;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned QUIET_AFTER  = 1000;

  class search_scoreboard;
    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [LEN_W-1:0]      pat_len;
    byte_t                 window [WINDOW_DEPTH];
    logic [15:0]           count;
    logic [15:0]           first_start;
    logic [15:0]           last_start;
    bit                    matched;
    bit                    overflowed;
    result_t               expected_q [$];
    int                    mismatches;

    function new();
      pat_low    = '0;
      pat_high   = '0;
      pat_len    = '0;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      count       = '0;
      first_start = '0;
      last_start  = '0;
      matched     = 0;
      overflowed  = 0;
    endfunction

    function int unsigned used_length();
      return (pat_len > PAT_SLOTS) ? PAT_SLOTS : pat_len;
    endfunction

    function byte_t pattern_byte(int unsigned k);
      return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAT_LOW:  pat_low  = data;
        CFG_PAT_HIGH: pat_high = data;
        CFG_PAT_LEN:  pat_len  = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(byte_t b);
      int unsigned len;
      bit          hit;
      len = used_length();
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      // saturated counter: byte shifts in, but no match is recorded
      if (count == COUNT_MAX) begin
        overflowed = 1;
        return;
      end
      count++;
      if (len == 0 || count < len) return;
      hit = 1;
      for (int k = 0; k < len; k++)
        if (window[len-1-k] != pattern_byte(k)) hit = 0;
      if (hit) begin
        if (!matched) first_start = 16'(count - len);
        last_start = 16'(count - len);
        matched    = 1;
      end
    endfunction

    function void note_beat(byte_t b, bit has, bit eot);
      result_t r;
      if (has) take_byte(b);
      if (!eot) return;
      r = '0;
      if (used_length() == 0) begin
        r.found       = 1;
        r.first_index = '0;
        r.last_index  = count;
      end else begin
        r.found       = matched;
        r.first_index = matched ? first_start : '0;
        r.last_index  = matched ? last_start : '0;
      end
      r.text_length = count;
      r.overflow    = overflowed;
      expected_q.push_back(r);
      clear_text();
    endfunction

    function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
      if (want === got) return;
      if (mismatches < 10)
        $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      result_t got;
      result_t want;
      got = data;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("result beat %h with nothing expected", data);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("first_index", want.first_index, got.first_index);
      compare_field("last_index", want.last_index, got.last_index);
      compare_field("text_length", want.text_length, got.text_length);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("pad", want.pad, got.pad);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk        = 0;
  logic                  rst_n      = 0;
  logic                  in_tvalid  = 0;
  logic                  in_tready;
  byte_t                 in_tdata   = '0;
  logic                  in_tuser   = 0;
  logic                  in_tlast   = 0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index  = CFG_PAT_LOW;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  search_scoreboard sb;
  bit               quiet      = 0;
  int unsigned      items_sent = 0;
  int unsigned      cycles     = 0;
  int unsigned      stall_left = 0;

  substring_first_last_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // random receiver back-pressure bursts, none started while quiet
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_beat(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_beat(byte_t b, bit has, bit eot);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    if (has || eot) items_sent++;
  endtask

  // bytes of one text; close either on the last byte or with a bare closing beat
  task automatic send_text(byte_t txt [$], bit close_alone);
    foreach (txt[i]) begin
      if (!quiet && $urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 0, 0);
      send_beat(txt[i], 1, !close_alone && i == txt.size() - 1);
    end
    if (close_alone || txt.size() == 0) send_beat(8'($urandom_range(0, 255)), 0, 1);
  endtask

  task automatic settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pattern(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                             logic [LEN_W-1:0] len);
    cfg_idx_t              regs [3] = '{CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN};
    logic [CFG_DATA_W-1:0] vals [3];
    vals = '{lo, hi, CFG_DATA_W'(len)};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
  endtask

  initial begin
    byte_t                 txt [$];
    byte_t                 alpha [4];
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [LEN_W-1:0]      len;
    int unsigned           n;
    int unsigned           plen;

    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // pattern left empty from reset
    txt = '{8'h00, 8'hFF, 8'h41};
    send_text(txt, 0);
    txt = {};
    send_text(txt, 1);
    send_beat(8'h5A, 0, 0);

    // pattern longer than the text
    set_pattern(64'h0000_0000_0063_6261, '0, 5'd3);
    txt = '{8'h61, 8'h62};
    send_text(txt, 1);

    // oversized length clamps to the full 16 bytes
    set_pattern('0, '1, 5'd31);
    txt = {};
    repeat (8) txt.push_back(8'h00);
    repeat (8) txt.push_back(8'hFF);
    send_text(txt, 0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = (items_sent >= QUIET_AFTER);
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : alpha[$urandom_range(0, 3)];
        hi[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : alpha[$urandom_range(0, 3)];
      end
      case ($urandom_range(0, 9))
        0:       len = 5'd0;
        1:       len = 5'd16;
        2:       len = 5'($urandom_range(17, 31));
        default: len = 5'($urandom_range(1, 5));
      endcase
      set_pattern(lo, hi, len);
      plen = (len > PAT_SLOTS) ? PAT_SLOTS : len;

      repeat ($urandom_range(2, 5)) begin
        txt = {};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 24);
        while (txt.size() < n) begin
          // splice in a full copy of the pattern now and then
          if (plen != 0 && $urandom_range(0, 11) == 0) begin
            for (int k = 0; k < plen; k++)
              txt.push_back((k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8]);
          end else if ($urandom_range(0, 9) == 0) begin
            txt.push_back(8'($urandom_range(0, 255)));
          end else begin
            txt.push_back(alpha[$urandom_range(0, 3)]);
          end
        end
        send_text(txt, $urandom_range(0, 2) == 0);
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
